// ----- hdl/mpls_pkg.sv -----
package mpls_pkg;

  // Level codes.
  localparam logic [2:0] LVL_OFF   = 3'd0;
  localparam logic [2:0] LVL_GPRS  = 3'd5;
  localparam logic [2:0] LVL_STUCK = 3'd6;
  localparam logic [2:0] LVL_NONE  = 3'd7;

  // Event codes carried in the operation field.
  localparam logic [2:0] OP_REQUEST = 3'd0;
  localparam logic [2:0] OP_REACHED = 3'd1;
  localparam logic [2:0] OP_FAILED  = 3'd2;
  localparam logic [2:0] OP_RETRY   = 3'd3;
  localparam logic [2:0] OP_WAKE    = 3'd4;
  localparam logic [2:0] OP_DONE    = 3'd5;

  // Sequence codes reported in the action field.
  localparam logic [3:0] ACT_NONE      = 4'd0;
  localparam logic [3:0] ACT_POWER_ON  = 4'd1;
  localparam logic [3:0] ACT_RESET     = 4'd2;
  localparam logic [3:0] ACT_POWER_OFF = 4'd3;
  localparam logic [3:0] ACT_PROMPT    = 4'd4;
  localparam logic [3:0] ACT_SIM       = 4'd5;
  localparam logic [3:0] ACT_NETWORK   = 4'd6;
  localparam logic [3:0] ACT_DISCON    = 4'd7;
  localparam logic [3:0] ACT_GPRS_OPEN = 4'd8;
  localparam logic [3:0] ACT_GPRS_CLS  = 4'd9;
  localparam logic [3:0] ACT_TASK      = 4'd10;
  localparam logic [3:0] ACT_SOCKET    = 4'd11;
  // Internal code only: jump straight to the stuck level.
  localparam logic [3:0] ACT_FAKE      = 4'd12;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Sequencer state held between items.
  typedef struct packed {
    logic [2:0] now;
    logic [2:0] goal;
    logic [2:0] via;
    logic       running;
  } mpls_state_t;

  // One decoded input item.
  typedef struct packed {
    logic [2:0] op;
    logic [2:0] lvl;
    logic       task_pending;
    logic       socket_pending;
  } mpls_item_t;

  // State plus the result fields produced while handling one item.
  typedef struct packed {
    mpls_state_t st;
    logic [3:0]  act;
    logic        newlev;
    logic        reached;
    logic        failed;
    logic        ign;
  } mpls_step_t;

endpackage

// ----- hdl/mpls_core.sv -----
module mpls_core (
  input  mpls_pkg::mpls_state_t st,
  input  logic [2:0]            forced_level,
  input  mpls_pkg::mpls_item_t  item,
  output mpls_pkg::mpls_step_t  res
);
  import mpls_pkg::*;

  // Sequence to start for a move from one level (row) to another (column).
  localparam logic [3:0] PATH_TAB [7][7] = '{
    '{ACT_NONE, ACT_POWER_ON, ACT_POWER_ON, ACT_POWER_ON, ACT_POWER_ON,
      ACT_POWER_ON, ACT_FAKE},
    '{ACT_PROMPT, ACT_NONE, ACT_PROMPT, ACT_PROMPT, ACT_PROMPT, ACT_PROMPT,
      ACT_PROMPT},
    '{ACT_POWER_OFF, ACT_POWER_OFF, ACT_NONE, ACT_SIM, ACT_SIM, ACT_SIM,
      ACT_FAKE},
    '{ACT_POWER_OFF, ACT_POWER_OFF, ACT_POWER_OFF, ACT_NONE, ACT_NETWORK,
      ACT_NETWORK, ACT_FAKE},
    '{ACT_POWER_OFF, ACT_POWER_OFF, ACT_POWER_OFF, ACT_POWER_OFF, ACT_NONE,
      ACT_GPRS_OPEN, ACT_FAKE},
    '{ACT_POWER_OFF, ACT_POWER_OFF, ACT_POWER_OFF, ACT_POWER_OFF,
      ACT_GPRS_CLS, ACT_NONE, ACT_DISCON},
    '{ACT_RESET, ACT_RESET, ACT_RESET, ACT_RESET, ACT_RESET, ACT_RESET,
      ACT_FAKE}
  };

  // A level is taken unless it is out of range or already current.
  function automatic mpls_step_t do_reach(mpls_step_t x, logic [2:0] lvl);
    mpls_step_t y;
    y = x;
    if (lvl == LVL_NONE || lvl == x.st.now) begin
      y.ign = 1'b1;
    end else begin
      if (x.st.via == lvl) begin
        y.st.via = LVL_NONE;
      end
      y.st.now     = lvl;
      y.newlev     = 1'b1;
      y.reached    = x.reached | (lvl == x.st.goal);
      y.st.running = 1'b0;
    end
    return y;
  endfunction

  // Priority: intermediate level, then target, then tasks, then sockets.
  function automatic logic [3:0] pick(mpls_state_t s, logic tsk, logic sck);
    logic [3:0] a;
    if (s.via != LVL_NONE && s.via != s.now) begin
      a = PATH_TAB[s.now][s.via];
    end else if (s.now != s.goal) begin
      a = PATH_TAB[s.now][s.goal];
    end else if (tsk) begin
      a = ACT_TASK;
    end else if (s.now >= LVL_GPRS && sck) begin
      a = ACT_SOCKET;
    end else begin
      a = ACT_NONE;
    end
    return a;
  endfunction

  // Evaluation when idle; a stuck jump lands on the stuck level and
  // evaluates once more from there.
  function automatic mpls_step_t do_eval(mpls_step_t x, logic tsk, logic sck);
    mpls_step_t y;
    logic [3:0] a;
    y = x;
    if (!x.st.running) begin
      a = pick(x.st, tsk, sck);
      if (a == ACT_FAKE) begin
        y = do_reach(y, LVL_STUCK);
        a = pick(y.st, tsk, sck);
      end
      if (a == ACT_FAKE) begin
        // Already at the stuck level: the jump is rejected and stays busy.
        y.st.running = 1'b1;
        y.ign        = 1'b1;
        y.act        = ACT_NONE;
      end else begin
        y.st.running = (a != ACT_NONE);
        y.act        = a;
      end
    end
    return y;
  endfunction

  mpls_step_t base;
  mpls_step_t tmp;

  always_comb begin
    base         = '0;
    base.st      = st;
    tmp          = base;
    res          = base;
    case (item.op)
      OP_REQUEST: begin
        if (forced_level != LVL_NONE) begin
          tmp.st.goal = forced_level;
        end else if (item.lvl != LVL_NONE) begin
          tmp.st.goal = item.lvl;
        end
        res = do_eval(tmp, item.task_pending, item.socket_pending);
      end
      OP_REACHED: begin
        res = do_reach(base, item.lvl);
      end
      OP_FAILED: begin
        if (st.goal == LVL_OFF) begin
          // A failed power-off leaves the hardware stuck.
          res = do_reach(base, LVL_STUCK);
        end else begin
          tmp.st.goal    = st.now;
          tmp.st.running = 1'b0;
          tmp.failed     = 1'b1;
          if (forced_level != LVL_NONE && st.now != forced_level) begin
            tmp.st.goal = forced_level;
            res = do_eval(tmp, item.task_pending, item.socket_pending);
          end else begin
            res = tmp;
          end
        end
      end
      OP_RETRY: begin
        tmp.st.via = item.lvl;
        res = do_eval(tmp, item.task_pending, item.socket_pending);
      end
      OP_WAKE: begin
        res = do_eval(base, item.task_pending, item.socket_pending);
      end
      OP_DONE: begin
        res.st.running = 1'b0;
      end
      default: begin
        res = base;
      end
    endcase
  end

endmodule

// ----- hdl/modem_power_level_sequencer.sv -----
// Channel  Direction  Width  Contents
// in_      input      8      operation, level, task_pending, socket_pending
// out_     output     16     action, levels, busy and event flags
// cfg_     input      3      forced_level write
//
// Each item is registered on entry, and its result is computed from the held
// state and loaded into the result register when that register is free or
// drains. One item is accepted per cycle while the result side is not stalled;
// the state update is table lookup and priority logic, looked up once more after
// a stuck jump, between the input register and the result register.
// Reset (rst_n low, synchronous) powers the sequencer off, clears forcing and
// empties both registers. A stalled result holds its register; the input
// register still takes one more item behind it.
module modem_power_level_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  // [2:0] operation, [5:3] level, [6] task_pending, [7] socket_pending
  input  logic [mpls_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [3:0] action, [6:4] present_level, [9:7] goal_level, [10] busy_res,
  // [11] new_level_event, [12] target_reached_event, [13] failed_event,
  // [14] ignored, [15] zero
  output logic [mpls_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic [2:0]                          cfg_wr_data
);
  import mpls_pkg::*;

  logic        s1_valid_r;
  mpls_item_t  s1_item_r;
  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  mpls_state_t st_r;
  logic [2:0]  forced_r;
  logic        advance;
  logic        in_take;
  mpls_step_t  step;

  // The held item moves on whenever the result register is free or drains.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  mpls_core u_core (
    .st           (st_r),
    .forced_level (forced_r),
    .item         (s1_item_r),
    .res          (step)
  );

  // Pack the result fields, highest field first.
  assign out_data_nxt = {1'b0, step.ign, step.failed, step.reached, step.newlev,
                         step.st.running, step.st.goal, step.st.now, step.act};

  // Control state, sequencer state and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      forced_r    <= LVL_NONE;
      st_r.now     <= LVL_OFF;
      st_r.goal    <= LVL_OFF;
      st_r.via     <= LVL_NONE;
      st_r.running <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= step.st;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        forced_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.op             <= in_tdata[2:0];
      s1_item_r.lvl            <= in_tdata[5:3];
      s1_item_r.task_pending   <= in_tdata[6];
      s1_item_r.socket_pending <= in_tdata[7];
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

endmodule

// ----- hdl/mpls_chk.sv -----
module mpls_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic [mpls_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready
);
  import mpls_pkg::*;

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // Any started sequence leaves the sequencer busy.
  a_act_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] != ACT_NONE |-> out_tdata[10])
    else $error("action started without busy flag");

  // Reaching the target implies a new level was taken and nothing was ignored.
  a_reach_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> out_tdata[11] && !out_tdata[14])
    else $error("inconsistent reach flags");

  // No result is shown right after a reset cycle.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind modem_power_level_sequencer mpls_chk u_mpls_chk (.*);

// ----- tb/tb_modem_power_level_sequencer.sv -----
module tb_modem_power_level_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import mpls_pkg::*;

  // Level codes that the package leaves unnamed.
  localparam logic [2:0] LVL_ON     = 3'd1;
  localparam logic [2:0] LVL_PROMPT = 3'd2;
  localparam logic [2:0] LVL_SIM    = 3'd3;
  localparam logic [2:0] LVL_NET    = 3'd4;

  localparam int LONG_HOLD   = 60;
  localparam int PHASE_ITEMS = 112;

  // One result item, fields from the highest bit down.
  typedef struct packed {
    logic       pad;
    logic       ign;
    logic       failed;
    logic       reached;
    logic       newlev;
    logic       busy;
    logic [2:0] goal;
    logic [2:0] now;
    logic [3:0] act;
  } status_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [2:0]            cfg_wr_data = '0;

  // Predictor state.
  logic [2:0] m_now;
  logic [2:0] m_goal;
  logic [2:0] m_via;
  logic       m_running;
  logic [2:0] m_forced;
  logic       f_new;
  logic       f_hit;
  logic       f_fail;
  logic       f_ign;

  logic [IN_DATA_W-1:0] item_q[$];
  status_t              expected_status_q[$];
  int                   queued_count = 0;
  int                   accepted_count = 0;
  int                   mismatches = 0;
  logic                 in_taken = 1'b0;
  logic                 out_taken = 1'b0;
  int                   in_gap = 0;
  int                   out_wait = 0;
  int                   hold_asked = 0;
  int                   hold_served = 0;
  logic                 calm = 1'b0;

  modem_power_level_sequencer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Sequence that moves the modem one step from one level toward another.
  function automatic logic [3:0] route_action(input logic [2:0] from, input logic [2:0] to);
    logic [3:0] a;
    a = ACT_NONE;
    case (from)
      LVL_OFF: begin
        if (to == LVL_STUCK) a = ACT_FAKE;
        else if (to != LVL_OFF) a = ACT_POWER_ON;
      end
      LVL_ON: begin
        if (to != LVL_ON) a = ACT_PROMPT;
      end
      LVL_PROMPT: begin
        if (to == LVL_STUCK) a = ACT_FAKE;
        else if (to < LVL_PROMPT) a = ACT_POWER_OFF;
        else if (to > LVL_PROMPT) a = ACT_SIM;
      end
      LVL_SIM: begin
        if (to == LVL_STUCK) a = ACT_FAKE;
        else if (to < LVL_SIM) a = ACT_POWER_OFF;
        else if (to > LVL_SIM) a = ACT_NETWORK;
      end
      LVL_NET: begin
        if (to == LVL_STUCK) a = ACT_FAKE;
        else if (to < LVL_NET) a = ACT_POWER_OFF;
        else if (to == LVL_GPRS) a = ACT_GPRS_OPEN;
      end
      LVL_GPRS: begin
        if (to == LVL_STUCK) a = ACT_DISCON;
        else if (to == LVL_NET) a = ACT_GPRS_CLS;
        else if (to < LVL_NET) a = ACT_POWER_OFF;
      end
      default: begin
        a = (to == LVL_STUCK) ? ACT_FAKE : ACT_RESET;
      end
    endcase
    return a;
  endfunction

  // A reached level is taken unless it is out of range or already held.
  function automatic void take_level(input logic [2:0] lvl);
    if (lvl > LVL_STUCK || lvl == m_now) begin
      f_ign = 1'b1;
    end else begin
      if (m_via == lvl) m_via = LVL_NONE;
      m_now = lvl;
      f_new = 1'b1;
      if (lvl == m_goal) f_hit = 1'b1;
      m_running = 1'b0;
    end
  endfunction

  function automatic void set_goal(input logic [2:0] lvl);
    if (m_forced != LVL_NONE) m_goal = m_forced;
    else if (lvl != LVL_NONE) m_goal = lvl;
  endfunction

  // Priority: intermediate level, target, task work, socket work.
  function automatic logic [3:0] next_work(input logic task_p, input logic sock_p);
    if (m_via != LVL_NONE && m_via != m_now) return route_action(m_now, m_via);
    if (m_now != m_goal) return route_action(m_now, m_goal);
    if (task_p) return ACT_TASK;
    if (m_now >= LVL_GPRS && sock_p) return ACT_SOCKET;
    return ACT_NONE;
  endfunction

  // The stuck shortcut lands at the stuck level and looks once more.
  function automatic logic [3:0] start_next(input logic task_p, input logic sock_p);
    logic [3:0] a;
    if (m_running) return ACT_NONE;
    for (int pass = 0; pass < 2; pass++) begin
      a = next_work(task_p, sock_p);
      if (a == ACT_FAKE) begin
        m_running = 1'b1;
        take_level(LVL_STUCK);
        if (m_running) return ACT_NONE;
      end else begin
        if (a != ACT_NONE) m_running = 1'b1;
        return a;
      end
    end
    return ACT_NONE;
  endfunction

  function automatic status_t sequencer_step(input logic [IN_DATA_W-1:0] item);
    status_t    r;
    logic [2:0] op;
    logic [2:0] lvl;
    logic       task_p;
    logic       sock_p;
    logic [3:0] act;
    op = item[2:0];
    lvl = item[5:3];
    task_p = item[6];
    sock_p = item[7];
    f_new = 1'b0;
    f_hit = 1'b0;
    f_fail = 1'b0;
    f_ign = 1'b0;
    act = ACT_NONE;
    case (op)
      OP_REQUEST: begin
        set_goal(lvl);
        act = start_next(task_p, sock_p);
      end
      OP_REACHED: take_level(lvl);
      OP_FAILED: begin
        // A failed power-off means the hardware is stuck.
        if (m_goal == LVL_OFF) begin
          take_level(LVL_STUCK);
        end else begin
          m_goal = m_now;
          m_running = 1'b0;
          f_fail = 1'b1;
          if (m_forced != LVL_NONE && m_goal != m_forced) begin
            set_goal(m_forced);
            act = start_next(task_p, sock_p);
          end
        end
      end
      OP_RETRY: begin
        m_via = lvl;
        act = start_next(task_p, sock_p);
      end
      OP_WAKE: act = start_next(task_p, sock_p);
      OP_DONE: m_running = 1'b0;
      default: ;
    endcase
    r = '0;
    r.act = act;
    r.now = m_now;
    r.goal = m_goal;
    r.busy = m_running;
    r.newlev = f_new;
    r.reached = f_hit;
    r.failed = f_fail;
    r.ign = f_ign;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [3:0] exp_v,
                                      input logic [3:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // Acceptance on both channels, prediction and comparison.
  always @(posedge clk) begin
    status_t e;
    status_t g;
    if (!rst_n) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      out_taken <= out_tvalid && out_tready;
      if (in_tvalid && in_tready) begin
        expected_status_q.push_back(sequencer_step(in_tdata));
        accepted_count++;
      end
      if (out_tvalid && out_tready) begin
        g = status_t'(out_tdata);
        if (expected_status_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none, got %h", $time, out_tdata);
        end else begin
          e = expected_status_q.pop_front();
          check_field("action", e.act, g.act);
          check_field("present_level", 4'(e.now), 4'(g.now));
          check_field("goal_level", 4'(e.goal), 4'(g.goal));
          check_field("busy", 4'(e.busy), 4'(g.busy));
          check_field("new_level_event", 4'(e.newlev), 4'(g.newlev));
          check_field("target_reached_event", 4'(e.reached), 4'(g.reached));
          check_field("failed_event", 4'(e.failed), 4'(g.failed));
          check_field("ignored", 4'(e.ign), 4'(g.ign));
          check_field("padding", 4'(e.pad), 4'(g.pad));
        end
      end
    end
  end

  // Input driver: holds an item until taken, then waits a drawn gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      in_tvalid <= 1'b1;
    end else if (in_gap > 0) begin
      in_tvalid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (item_q.size() > 0) begin
      in_tdata <= item_q.pop_front();
      in_tvalid <= 1'b1;
      in_gap <= draw_wait();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result receiver: a drawn stall after each item, and long holds on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait = 0;
    end else begin
      if (hold_asked != hold_served) begin
        out_wait = LONG_HOLD;
        hold_served = hold_asked;
      end else if (out_taken) begin
        out_wait = draw_wait();
      end else if (out_wait > 0) begin
        out_wait = out_wait - 1;
      end
      out_tready <= (out_wait == 0);
    end
  end

  function automatic logic [IN_DATA_W-1:0] make_item(input logic [2:0] op, input logic [2:0] lvl,
                                                     input logic task_p, input logic sock_p);
    return {sock_p, task_p, lvl, op};
  endfunction

  task automatic add_item(input logic [IN_DATA_W-1:0] item);
    item_q.push_back(item);
    queued_count++;
  endtask

  function automatic logic [2:0] random_level();
    return ($urandom_range(0, 9) == 0) ? LVL_NONE : 3'($urandom_range(0, 6));
  endfunction

  // A plausible exchange: a request, then wake and reached steps, then work done.
  task automatic add_session();
    int steps;
    steps = $urandom_range(2, 6);
    add_item(make_item(OP_REQUEST, random_level(), 1'($urandom), 1'($urandom)));
    repeat (steps) begin
      add_item(make_item(OP_WAKE, random_level(), 1'($urandom), 1'($urandom)));
      add_item(make_item(OP_REACHED, 3'($urandom_range(0, 6)), 1'($urandom), 1'($urandom)));
    end
    add_item(make_item(OP_DONE, random_level(), 1'($urandom), 1'($urandom)));
  endtask

  task automatic add_random_item();
    logic [2:0] op;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) op = OP_REQUEST;
    else if (roll < 50) op = OP_REACHED;
    else if (roll < 66) op = OP_WAKE;
    else if (roll < 78) op = OP_FAILED;
    else if (roll < 88) op = OP_RETRY;
    else if (roll < 96) op = OP_DONE;
    else op = OP_DONE + 3'($urandom_range(1, 2));
    add_item(make_item(op, 3'($urandom), 1'($urandom), 1'($urandom)));
  endtask

  // Wait until every item has been taken and every result has come back.
  task automatic drain();
    while (accepted_count != queued_count || expected_status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_forced(input logic [2:0] lvl);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lvl;
    m_forced = lvl;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stimulus: directed walk through the levels, then random phases per forced level.
  initial begin
    logic [2:0] forced_plan[7];
    int         goal_count;
    forced_plan = '{LVL_NONE, LVL_OFF, LVL_STUCK, LVL_SIM, LVL_GPRS, LVL_ON, LVL_NONE};
    m_now = LVL_OFF;
    m_goal = LVL_OFF;
    m_via = LVL_NONE;
    m_running = 1'b0;
    m_forced = LVL_NONE;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Climb from off to GPRS one sequence at a time.
    add_item(make_item(OP_WAKE, LVL_OFF, 1'b0, 1'b0));
    add_item(make_item(OP_REQUEST, LVL_GPRS, 1'b0, 1'b0));
    add_item(make_item(OP_REACHED, LVL_ON, 1'b0, 1'b0));
    add_item(make_item(OP_REACHED, LVL_ON, 1'b0, 1'b0));
    add_item(make_item(OP_REACHED, LVL_NONE, 1'b1, 1'b1));
    add_item(make_item(OP_WAKE, LVL_OFF, 1'b0, 1'b0));
    add_item(make_item(OP_REACHED, LVL_PROMPT, 1'b0, 1'b0));
    add_item(make_item(OP_WAKE, LVL_OFF, 1'b0, 1'b0));
    add_item(make_item(OP_REACHED, LVL_SIM, 1'b0, 1'b0));
    add_item(make_item(OP_WAKE, LVL_OFF, 1'b0, 1'b0));
    add_item(make_item(OP_REACHED, LVL_NET, 1'b0, 1'b0));
    add_item(make_item(OP_WAKE, LVL_OFF, 1'b0, 1'b0));
    add_item(make_item(OP_REACHED, LVL_GPRS, 1'b0, 1'b0));
    // Task work first, wake while busy, then socket work.
    add_item(make_item(OP_WAKE, LVL_OFF, 1'b1, 1'b1));
    add_item(make_item(OP_WAKE, LVL_OFF, 1'b1, 1'b1));
    add_item(make_item(OP_DONE, LVL_OFF, 1'b0, 1'b0));
    add_item(make_item(OP_WAKE, LVL_OFF, 1'b0, 1'b1));
    add_item(make_item(OP_DONE, LVL_OFF, 1'b0, 1'b0));
    // Unset request level, retry through an intermediate level, clear it.
    add_item(make_item(OP_REQUEST, LVL_NONE, 1'b0, 1'b0));
    add_item(make_item(OP_RETRY, LVL_SIM, 1'b0, 1'b0));
    add_item(make_item(OP_REACHED, LVL_SIM, 1'b0, 1'b0));
    add_item(make_item(OP_RETRY, LVL_NONE, 1'b0, 1'b0));
    add_item(make_item(OP_FAILED, LVL_OFF, 1'b0, 1'b0));
    // Stuck shortcut, power off, then a failed power-off.
    add_item(make_item(OP_REQUEST, LVL_STUCK, 1'b1, 1'b0));
    add_item(make_item(OP_DONE, LVL_OFF, 1'b0, 1'b0));
    add_item(make_item(OP_REQUEST, LVL_OFF, 1'b0, 1'b0));
    add_item(make_item(OP_REACHED, LVL_OFF, 1'b0, 1'b0));
    add_item(make_item(OP_FAILED, LVL_OFF, 1'b0, 1'b0));
    add_item(make_item(OP_DONE + 3'd1, LVL_NONE, 1'b1, 1'b1));
    add_item(make_item(OP_DONE + 3'd2, LVL_NONE, 1'b1, 1'b1));

    foreach (forced_plan[p]) begin
      drain();
      write_forced(forced_plan[p]);
      calm = (p == 3);
      goal_count = queued_count + PHASE_ITEMS;
      while (queued_count < goal_count) begin
        if ($urandom_range(0, 2) == 0) add_session();
        else add_random_item();
      end
      // Block the results long enough for the input side to back up.
      if (p == 2 || p == 5) hold_asked++;
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && expected_status_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
